// ===== src/dmv_pkg.sv =====
// Shared types and constants for the dead-man vigilance controller.
`timescale 1ns / 1ps

package dmv_pkg;

    localparam int CFG_WIDTH     = 16;
    localparam int ELAPSED_WIDTH = 17;
    localparam int SPEED_WIDTH   = 9;
    localparam int MODE_WIDTH    = 3;
    localparam int APB_DATA_WIDTH = 32;
    localparam int APB_ADDR_WIDTH = 4;

    localparam logic [ELAPSED_WIDTH-1:0] ELAPSED_MAX = '1;

    localparam logic [CFG_WIDTH-1:0] HOLD_START_RESET     = 16'd55000;
    localparam logic [CFG_WIDTH-1:0] RELEASED_START_RESET = 16'd5000;
    localparam logic [CFG_WIDTH-1:0] ALARM_DURATION_RESET = 16'd5000;

    // Register indexes (word address bits of paddr).
    localparam logic [1:0] REG_HOLD_START     = 2'd0;
    localparam logic [1:0] REG_RELEASED_START = 2'd1;
    localparam logic [1:0] REG_ALARM_DURATION = 2'd2;

    typedef enum logic [MODE_WIDTH-1:0] {
        MODE_OFF            = 3'd0,
        MODE_HELD           = 3'd1,
        MODE_HELD_ALARM     = 3'd2,
        MODE_RELEASED       = 3'd3,
        MODE_RELEASED_ALARM = 3'd4,
        MODE_EMERGENCY      = 3'd5
    } mode_t;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] hold_start;
        logic [CFG_WIDTH-1:0] released_start;
        logic [CFG_WIDTH-1:0] alarm_duration;
    } cfg_t;

    typedef struct packed {
        logic [SPEED_WIDTH-1:0] speed_kmh;
        logic                   zone_key_on;
        logic                   pedal_held;
    } tick_t;

    typedef struct packed {
        logic [MODE_WIDTH-1:0] mode;
        logic                  hold_alarm;
        logic                  released_alarm;
        logic                  emergency_brake;
    } result_t;

endpackage

// ===== src/dmv_cfg_regs.sv =====
// APB configuration registers for the vigilance timing limits.
`timescale 1ns / 1ps

module dmv_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dmv_pkg::APB_ADDR_WIDTH-1:0]  paddr,
    input  logic [dmv_pkg::APB_DATA_WIDTH-1:0]  pwdata,
    output logic [dmv_pkg::APB_DATA_WIDTH-1:0]  prdata,
    output logic                                pready,
    output dmv_pkg::cfg_t                       cfg
);

    dmv_pkg::cfg_t cfg_reg;
    logic [1:0]    index;
    logic          wr_en;
    logic [dmv_pkg::CFG_WIDTH-1:0] rd_value;

    assign pready = 1'b1;
    assign index  = paddr[3:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_start     <= dmv_pkg::HOLD_START_RESET;
            cfg_reg.released_start <= dmv_pkg::RELEASED_START_RESET;
            cfg_reg.alarm_duration <= dmv_pkg::ALARM_DURATION_RESET;
        end
        else if (wr_en)
        begin
            case (index)
                dmv_pkg::REG_HOLD_START:
                    cfg_reg.hold_start <= pwdata[dmv_pkg::CFG_WIDTH-1:0];
                dmv_pkg::REG_RELEASED_START:
                    cfg_reg.released_start <= pwdata[dmv_pkg::CFG_WIDTH-1:0];
                dmv_pkg::REG_ALARM_DURATION:
                    cfg_reg.alarm_duration <= pwdata[dmv_pkg::CFG_WIDTH-1:0];
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            dmv_pkg::REG_HOLD_START:     rd_value = cfg_reg.hold_start;
            dmv_pkg::REG_RELEASED_START: rd_value = cfg_reg.released_start;
            dmv_pkg::REG_ALARM_DURATION: rd_value = cfg_reg.alarm_duration;
            default:                     rd_value = '0;
        endcase
    end

    assign prdata = {{(dmv_pkg::APB_DATA_WIDTH-dmv_pkg::CFG_WIDTH){1'b0}}, rd_value};

endmodule

// ===== src/dmv_mode_fsm.sv =====
// Vigilance mode state machine with the elapsed-time counter.
`timescale 1ns / 1ps

module dmv_mode_fsm (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  dmv_pkg::tick_t    tick,
    input  dmv_pkg::cfg_t     cfg,
    output dmv_pkg::result_t  result
);

    dmv_pkg::mode_t mode_reg, mode_next;
    logic [dmv_pkg::ELAPSED_WIDTH-1:0] elapsed_reg, elapsed_next, elapsed_inc;
    logic [dmv_pkg::ELAPSED_WIDTH-1:0] hold_limit, released_limit, duration_limit;
    logic armed;

    assign armed = (tick.speed_kmh != '0) || tick.zone_key_on;

    // The counter grows before the limit compares, so a limit of N allows N ticks.
    assign elapsed_inc = (elapsed_reg == dmv_pkg::ELAPSED_MAX) ?
                         elapsed_reg : elapsed_reg + 1'b1;

    assign hold_limit     = {1'b0, cfg.hold_start};
    assign released_limit = {1'b0, cfg.released_start};
    assign duration_limit = {1'b0, cfg.alarm_duration};

    always_comb
    begin
        mode_next = mode_reg;
        case (mode_reg)
            dmv_pkg::MODE_OFF:
            begin
                if (armed)
                    mode_next = tick.pedal_held ? dmv_pkg::MODE_HELD : dmv_pkg::MODE_RELEASED;
            end
            dmv_pkg::MODE_HELD:
            begin
                if (!armed)
                    mode_next = dmv_pkg::MODE_OFF;
                else if (elapsed_inc > hold_limit)
                    mode_next = dmv_pkg::MODE_HELD_ALARM;
                else if (!tick.pedal_held)
                    mode_next = dmv_pkg::MODE_RELEASED;
            end
            dmv_pkg::MODE_HELD_ALARM:
            begin
                if (!armed)
                    mode_next = dmv_pkg::MODE_OFF;
                else if (elapsed_inc > duration_limit)
                    mode_next = dmv_pkg::MODE_EMERGENCY;
                else if (!tick.pedal_held)
                    mode_next = dmv_pkg::MODE_RELEASED;
            end
            dmv_pkg::MODE_RELEASED:
            begin
                if (!armed)
                    mode_next = dmv_pkg::MODE_OFF;
                else if (elapsed_inc > released_limit)
                    mode_next = dmv_pkg::MODE_RELEASED_ALARM;
                else if (tick.pedal_held)
                    mode_next = dmv_pkg::MODE_HELD;
            end
            dmv_pkg::MODE_RELEASED_ALARM:
            begin
                if (!armed)
                    mode_next = dmv_pkg::MODE_OFF;
                else if (elapsed_inc > duration_limit)
                    mode_next = dmv_pkg::MODE_EMERGENCY;
                else if (tick.pedal_held)
                    mode_next = dmv_pkg::MODE_HELD;
            end
            default:
                // Emergency is latched until reset.
                mode_next = mode_reg;
        endcase
    end

    assign elapsed_next = (mode_next != mode_reg) ? '0 : elapsed_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= dmv_pkg::MODE_OFF;
            elapsed_reg <= '0;
        end
        else if (advance)
        begin
            mode_reg    <= mode_next;
            elapsed_reg <= elapsed_next;
        end
    end

    // Result fields describe the mode after this tick.
    always_comb
    begin
        result.mode            = mode_next;
        result.hold_alarm      = (mode_next == dmv_pkg::MODE_HELD_ALARM);
        result.released_alarm  = (mode_next == dmv_pkg::MODE_RELEASED_ALARM);
        result.emergency_brake = (mode_next == dmv_pkg::MODE_EMERGENCY);
    end

endmodule

// ===== src/dead_man_vigilance_controller.sv =====
// Top level of the dead-man vigilance controller.
//
// Usage: send one request per millisecond tick on the input channel
// (in_valid/in_ready) carrying speed_kmh, zone_key_on and pedal_held.
// Each request yields exactly one result on the output channel
// (out_valid/out_ready): mode, hold_alarm, released_alarm, emergency_brake,
// which describe the state after that tick.
// Timing limits are written through the APB port (0x0 hold start,
// 0x4 released start, 0x8 alarm duration); write them only while idle.
// Pipeline: a request is captured in the input register at the edge that accepts
// it and its result moves to the result register, raising out_valid, once the
// result slot is free. Throughput is one request per cycle while out_ready stays
// high; the mode update between the two registers is a single pass of compares.
// A stalled receiver holds the result register; the input register then
// holds one more request and in_ready drops until the result is taken.
// Reset returns the mode to off, clears the elapsed counter and the
// pipeline, and restores the limits to 55000, 5000 and 5000 ms.
`timescale 1ns / 1ps

module dead_man_vigilance_controller (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [dmv_pkg::SPEED_WIDTH-1:0]     speed_kmh,
    input  logic                                zone_key_on,
    input  logic                                pedal_held,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [dmv_pkg::MODE_WIDTH-1:0]      mode,
    output logic                                hold_alarm,
    output logic                                released_alarm,
    output logic                                emergency_brake,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dmv_pkg::APB_ADDR_WIDTH-1:0]  paddr,
    input  logic [dmv_pkg::APB_DATA_WIDTH-1:0]  pwdata,
    output logic [dmv_pkg::APB_DATA_WIDTH-1:0]  prdata,
    output logic                                pready
);

    dmv_pkg::cfg_t    cfg;
    dmv_pkg::tick_t   tick_reg;
    dmv_pkg::result_t result_comb, result_reg;
    logic in_valid_reg, out_valid_reg, advance;

    // The tick in the input register moves on when the result slot is free.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    dmv_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dmv_mode_fsm u_fsm (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .tick    (tick_reg),
        .cfg     (cfg),
        .result  (result_comb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            tick_reg.speed_kmh   <= speed_kmh;
            tick_reg.zone_key_on <= zone_key_on;
            tick_reg.pedal_held  <= pedal_held;
        end
        if (advance)
            result_reg <= result_comb;
    end

    assign out_valid       = out_valid_reg;
    assign mode            = result_reg.mode;
    assign hold_alarm      = result_reg.hold_alarm;
    assign released_alarm  = result_reg.released_alarm;
    assign emergency_brake = result_reg.emergency_brake;

endmodule

// ===== src/dmv_checker.sv =====
// Port-level checker for the vigilance controller and its bind.
`timescale 1ns / 1ps

module dmv_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [dmv_pkg::MODE_WIDTH-1:0]  mode,
    input logic                            hold_alarm,
    input logic                            released_alarm,
    input logic                            emergency_brake,
    input logic                            pready
);

    logic brake_seen_reg;

    // Remembers that an emergency result has been delivered since reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            brake_seen_reg <= 1'b0;
        else if (out_valid && out_ready && emergency_brake)
            brake_seen_reg <= 1'b1;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(mode))
        else $error("result changed while stalled");

    a_flags_match_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hold_alarm == (mode == dmv_pkg::MODE_HELD_ALARM))
                   && (released_alarm == (mode == dmv_pkg::MODE_RELEASED_ALARM))
                   && (emergency_brake == (mode == dmv_pkg::MODE_EMERGENCY)))
        else $error("alarm flags disagree with mode");

    a_brake_latched: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && brake_seen_reg |-> emergency_brake)
        else $error("emergency brake released without reset");

    a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind dead_man_vigilance_controller dmv_checker u_dmv_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .mode            (mode),
    .hold_alarm      (hold_alarm),
    .released_alarm  (released_alarm),
    .emergency_brake (emergency_brake),
    .pready          (pready)
);

// ===== tb/sv/vigilance_tracker.sv =====
// Mode predictor and result checker used by the vigilance controller testbench.
`timescale 1ns / 1ps

package dmv_tb_pkg;

    class vigilance_tracker;
        logic [dmv_pkg::CFG_WIDTH-1:0]     hold_start;
        logic [dmv_pkg::CFG_WIDTH-1:0]     released_start;
        logic [dmv_pkg::CFG_WIDTH-1:0]     alarm_duration;
        dmv_pkg::mode_t                    cur_mode;
        logic [dmv_pkg::ELAPSED_WIDTH-1:0] elapsed_ms;
        dmv_pkg::result_t                  status_due_q[$];
        int                                n_ticks;
        int                                n_checked;
        int                                n_errors;
        int                                mode_ticks[6];

        function new();
            hold_start     = dmv_pkg::HOLD_START_RESET;
            released_start = dmv_pkg::RELEASED_START_RESET;
            alarm_duration = dmv_pkg::ALARM_DURATION_RESET;
            cur_mode       = dmv_pkg::MODE_OFF;
            elapsed_ms     = '0;
            n_ticks        = 0;
            n_checked      = 0;
            n_errors       = 0;
            foreach (mode_ticks[i])
                mode_ticks[i] = 0;
        endfunction

        function void write_limit(logic [1:0] idx,
                                  logic [dmv_pkg::APB_DATA_WIDTH-1:0] value);
            case (idx)
                dmv_pkg::REG_HOLD_START:
                    hold_start = value[dmv_pkg::CFG_WIDTH-1:0];
                dmv_pkg::REG_RELEASED_START:
                    released_start = value[dmv_pkg::CFG_WIDTH-1:0];
                dmv_pkg::REG_ALARM_DURATION:
                    alarm_duration = value[dmv_pkg::CFG_WIDTH-1:0];
                default: ;
            endcase
        endfunction

        function logic [dmv_pkg::CFG_WIDTH-1:0] read_limit(logic [1:0] idx);
            logic [dmv_pkg::CFG_WIDTH-1:0] value;
            case (idx)
                dmv_pkg::REG_HOLD_START:     value = hold_start;
                dmv_pkg::REG_RELEASED_START: value = released_start;
                dmv_pkg::REG_ALARM_DURATION: value = alarm_duration;
                default:                     value = '0;
            endcase
            return value;
        endfunction

        // Advances the mode by one millisecond tick and queues the status it leaves behind.
        function void note_tick(dmv_pkg::tick_t t);
            logic             armed;
            dmv_pkg::mode_t   next_mode;
            dmv_pkg::result_t status;
            armed = (t.speed_kmh != '0) || t.zone_key_on;
            if (elapsed_ms != dmv_pkg::ELAPSED_MAX)
                elapsed_ms = elapsed_ms + 1'b1;
            next_mode = cur_mode;
            case (cur_mode)
                dmv_pkg::MODE_OFF:
                begin
                    if (armed && t.pedal_held)
                        next_mode = dmv_pkg::MODE_HELD;
                    else if (armed)
                        next_mode = dmv_pkg::MODE_RELEASED;
                end
                dmv_pkg::MODE_HELD:
                begin
                    if (!armed)
                        next_mode = dmv_pkg::MODE_OFF;
                    else if (elapsed_ms > hold_start)
                        next_mode = dmv_pkg::MODE_HELD_ALARM;
                    else if (!t.pedal_held)
                        next_mode = dmv_pkg::MODE_RELEASED;
                end
                dmv_pkg::MODE_HELD_ALARM:
                begin
                    if (!armed)
                        next_mode = dmv_pkg::MODE_OFF;
                    else if (elapsed_ms > alarm_duration)
                        next_mode = dmv_pkg::MODE_EMERGENCY;
                    else if (!t.pedal_held)
                        next_mode = dmv_pkg::MODE_RELEASED;
                end
                dmv_pkg::MODE_RELEASED:
                begin
                    if (!armed)
                        next_mode = dmv_pkg::MODE_OFF;
                    else if (elapsed_ms > released_start)
                        next_mode = dmv_pkg::MODE_RELEASED_ALARM;
                    else if (t.pedal_held)
                        next_mode = dmv_pkg::MODE_HELD;
                end
                dmv_pkg::MODE_RELEASED_ALARM:
                begin
                    if (!armed)
                        next_mode = dmv_pkg::MODE_OFF;
                    else if (elapsed_ms > alarm_duration)
                        next_mode = dmv_pkg::MODE_EMERGENCY;
                    else if (t.pedal_held)
                        next_mode = dmv_pkg::MODE_HELD;
                end
                default: ;  // Emergency holds until reset.
            endcase
            if (next_mode != cur_mode)
            begin
                cur_mode   = next_mode;
                elapsed_ms = '0;
            end
            status.mode            = cur_mode;
            status.hold_alarm      = (cur_mode == dmv_pkg::MODE_HELD_ALARM);
            status.released_alarm  = (cur_mode == dmv_pkg::MODE_RELEASED_ALARM);
            status.emergency_brake = (cur_mode == dmv_pkg::MODE_EMERGENCY);
            status_due_q.push_back(status);
            mode_ticks[cur_mode]++;
            n_ticks++;
        endfunction

        function void check_status(dmv_pkg::result_t got);
            dmv_pkg::result_t want;
            if (status_due_q.size() == 0)
            begin
                $error("mode: expected no result, got %0d", got.mode);
                n_errors++;
            end
            else
            begin
                want = status_due_q.pop_front();
                n_checked++;
                if (got.mode !== want.mode)
                begin
                    $error("mode: expected %0d, got %0d", want.mode, got.mode);
                    n_errors++;
                end
                if (got.hold_alarm !== want.hold_alarm)
                begin
                    $error("hold_alarm: expected %0b, got %0b",
                           want.hold_alarm, got.hold_alarm);
                    n_errors++;
                end
                if (got.released_alarm !== want.released_alarm)
                begin
                    $error("released_alarm: expected %0b, got %0b",
                           want.released_alarm, got.released_alarm);
                    n_errors++;
                end
                if (got.emergency_brake !== want.emergency_brake)
                begin
                    $error("emergency_brake: expected %0b, got %0b",
                           want.emergency_brake, got.emergency_brake);
                    n_errors++;
                end
            end
        endfunction

        function int pending();
            return status_due_q.size();
        endfunction
    endclass

endpackage

// ===== tb/sv/tb.sv =====
// Top-level testbench for the dead-man vigilance controller.
`timescale 1ns / 1ps

module tb;

    localparam int         WATCHDOG_LIMIT = 1000;
    localparam int         SETTLE_CYCLES  = 4;
    localparam int         PHASE_TICKS    = 75;
    localparam logic [1:0] REG_SPARE      = 2'd3;  // Decodes to no register.

    logic                               clk             = 1'b0;
    logic                               rst_n           = 1'b0;
    logic                               in_valid        = 1'b0;
    logic                               in_ready;
    logic [dmv_pkg::SPEED_WIDTH-1:0]    speed_kmh       = '0;
    logic                               zone_key_on     = 1'b0;
    logic                               pedal_held      = 1'b0;
    logic                               out_valid;
    logic                               out_ready       = 1'b0;
    logic [dmv_pkg::MODE_WIDTH-1:0]     mode;
    logic                               hold_alarm;
    logic                               released_alarm;
    logic                               emergency_brake;
    logic                               psel            = 1'b0;
    logic                               penable         = 1'b0;
    logic                               pwrite          = 1'b0;
    logic [dmv_pkg::APB_ADDR_WIDTH-1:0] paddr           = '0;
    logic [dmv_pkg::APB_DATA_WIDTH-1:0] pwdata          = '0;
    logic [dmv_pkg::APB_DATA_WIDTH-1:0] prdata;
    logic                               pready;

    dmv_tb_pkg::vigilance_tracker tracker;
    bit               tx_idle_en   = 1'b1;
    bit               rx_idle_en   = 1'b1;
    int               stall_left   = 0;
    int               quiet_cycles = 0;
    int               n_settings   = 1;
    logic             pedal_level  = 1'b0;

    dead_man_vigilance_controller uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .speed_kmh       (speed_kmh),
        .zone_key_on     (zone_key_on),
        .pedal_held      (pedal_held),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .mode            (mode),
        .hold_alarm      (hold_alarm),
        .released_alarm  (released_alarm),
        .emergency_brake (emergency_brake),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #10 clk = ~clk;

    // Result side: check every accepted status and stall in random bursts.
    always @(posedge clk)
    begin
        dmv_pkg::result_t got;
        if (out_valid && out_ready)
        begin
            got.mode            = mode;
            got.hold_alarm      = hold_alarm;
            got.released_alarm  = released_alarm;
            got.emergency_brake = emergency_brake;
            tracker.check_status(got);
        end
        if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left = stall_left - 1;
        end
        else if (rx_idle_en && $urandom_range(0, 5) == 0)
        begin
            out_ready  <= 1'b0;
            stall_left = $urandom_range(0, 6);
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("dead_man_vigilance_controller regression: fail");
            $finish;
        end
        else
            quiet_cycles = quiet_cycles + 1;
    end

    // Holds the request until it is taken; valid is left high for a following request.
    task automatic send_tick(input dmv_pkg::tick_t t);
        int gap;
        if (tx_idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 7);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        speed_kmh   <= t.speed_kmh;
        zone_key_on <= t.zone_key_on;
        pedal_held  <= t.pedal_held;
        do @(posedge clk); while (!in_ready);
        tracker.note_tick(t);
    endtask

    task automatic send_fields(input logic [dmv_pkg::SPEED_WIDTH-1:0] speed,
                               input logic key, input logic pedal);
        dmv_pkg::tick_t t;
        t.speed_kmh   = speed;
        t.zone_key_on = key;
        t.pedal_held  = pedal;
        send_tick(t);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [1:0] idx,
                             input logic [dmv_pkg::CFG_WIDTH-1:0] value);
        logic [dmv_pkg::APB_DATA_WIDTH-1:0] data;
        data = $urandom;  // Junk in the upper half must be ignored.
        data[dmv_pkg::CFG_WIDTH-1:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        tracker.write_limit(idx, data);
    endtask

    task automatic apb_read_check(input logic [1:0] idx);
        logic [dmv_pkg::APB_DATA_WIDTH-1:0] want;
        want = '0;
        want[dmv_pkg::CFG_WIDTH-1:0] = tracker.read_limit(idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want)
        begin
            $error("prdata of register %0d: expected %0d, got %0d", idx, want, prdata);
            tracker.n_errors++;
        end
    endtask

    task automatic check_limits();
        apb_read_check(dmv_pkg::REG_HOLD_START);
        apb_read_check(dmv_pkg::REG_RELEASED_START);
        apb_read_check(dmv_pkg::REG_ALARM_DURATION);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_limits(input logic [dmv_pkg::CFG_WIDTH-1:0] hold,
                               input logic [dmv_pkg::CFG_WIDTH-1:0] rel,
                               input logic [dmv_pkg::CFG_WIDTH-1:0] dur,
                               input bit poke_spare);
        int spare_draw;
        spare_draw = $urandom;
        wait_drained();
        apb_write(dmv_pkg::REG_HOLD_START, hold);
        apb_write(dmv_pkg::REG_RELEASED_START, rel);
        apb_write(dmv_pkg::REG_ALARM_DURATION, dur);
        if (poke_spare)
            apb_write(REG_SPARE, spare_draw[dmv_pkg::CFG_WIDTH-1:0]);
        check_limits();
        n_settings++;
    endtask

    function automatic dmv_pkg::tick_t gen_tick(input bit allow_brake);
        dmv_pkg::tick_t                    t;
        logic [dmv_pkg::ELAPSED_WIDTH-1:0] next_ms;
        int                                pick;
        int                                speed_draw;
        int                                key_draw;
        pick       = $urandom_range(0, 9);
        speed_draw = $urandom_range(1, 510);
        key_draw   = $urandom_range(0, 1);
        if (pick == 0)
            t.speed_kmh = '0;
        else if (pick == 1)
            t.speed_kmh = '1;
        else
            t.speed_kmh = speed_draw[dmv_pkg::SPEED_WIDTH-1:0];
        t.zone_key_on = key_draw[0];
        if ($urandom_range(0, 4) == 0)
            pedal_level = ~pedal_level;
        if ($urandom_range(0, 19) == 0)
        begin
            t.speed_kmh   = '0;
            t.zone_key_on = 1'b0;
        end
        next_ms = (tracker.elapsed_ms == dmv_pkg::ELAPSED_MAX) ? tracker.elapsed_ms
                                                               : tracker.elapsed_ms + 1'b1;
        if (!allow_brake && (tracker.cur_mode == dmv_pkg::MODE_HELD_ALARM ||
                             tracker.cur_mode == dmv_pkg::MODE_RELEASED_ALARM))
        begin
            // Once the duration runs out only a disarm avoids the latch; on the last
            // tick before that a pedal change also leaves the alarm.
            if (next_ms > tracker.alarm_duration)
            begin
                t.speed_kmh   = '0;
                t.zone_key_on = 1'b0;
            end
            else if (next_ms == tracker.alarm_duration && $urandom_range(0, 1) == 1)
                pedal_level = (tracker.cur_mode == dmv_pkg::MODE_RELEASED_ALARM);
        end
        t.pedal_held = pedal_level;
        return t;
    endfunction

    task automatic run_random(input int n, input bit allow_brake, input bit vary_idle);
        for (int i = 0; i < n; i++)
        begin
            if (vary_idle && i % 25 == 0)
            begin
                tx_idle_en = ($urandom_range(0, 2) != 0);
                rx_idle_en = ($urandom_range(0, 2) != 0);
            end
            send_tick(gen_tick(allow_brake));
        end
    endtask

    initial
    begin
        int r_hold;
        int r_rel;
        int r_dur;
        tracker = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_limits();

        // With the reset limits no alarm is reachable: arming, pedal changes, disarming.
        send_fields(9'd0, 1'b0, 1'b0);
        send_fields(9'd0, 1'b0, 1'b1);
        send_fields(9'd0, 1'b1, 1'b1);
        send_fields(9'd511, 1'b0, 1'b1);
        send_fields(9'd511, 1'b0, 1'b0);
        send_fields(9'd1, 1'b0, 1'b1);
        send_fields(9'd0, 1'b0, 1'b1);
        send_fields(9'd256, 1'b1, 1'b0);
        send_fields(9'd0, 1'b0, 1'b0);

        // Short limits: both alarms, each left by a pedal change, the released alarm also by a disarm.
        load_limits(16'd2, 16'd1, 16'd3, 1'b1);
        repeat (4) send_fields(9'd5, 1'b0, 1'b1);
        send_fields(9'd5, 1'b0, 1'b1);
        send_fields(9'd5, 1'b0, 1'b0);
        repeat (2) send_fields(9'd5, 1'b0, 1'b0);
        send_fields(9'd5, 1'b0, 1'b1);
        send_fields(9'd0, 1'b0, 1'b1);
        repeat (3) send_fields(9'd0, 1'b1, 1'b0);
        send_fields(9'd0, 1'b0, 1'b0);

        load_limits(16'd3, 16'd2, 16'd4, 1'b0);
        run_random(PHASE_TICKS, 1'b0, 1'b1);
        load_limits(16'd0, 16'd0, 16'd0, 1'b0);
        run_random(PHASE_TICKS, 1'b0, 1'b1);
        load_limits(16'd7, 16'd1, 16'd2, 1'b0);
        run_random(PHASE_TICKS, 1'b0, 1'b1);
        load_limits(16'd1, 16'd6, 16'd0, 1'b0);
        run_random(PHASE_TICKS, 1'b0, 1'b1);
        r_hold = $urandom_range(0, 12);
        r_rel  = $urandom_range(0, 12);
        r_dur  = $urandom_range(0, 12);
        load_limits(r_hold[dmv_pkg::CFG_WIDTH-1:0], r_rel[dmv_pkg::CFG_WIDTH-1:0],
                    r_dur[dmv_pkg::CFG_WIDTH-1:0], 1'b0);
        run_random(PHASE_TICKS, 1'b0, 1'b1);
        load_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        run_random(PHASE_TICKS, 1'b0, 1'b1);

        // Last stretch runs without idling: latch emergency and show that nothing clears it.
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        load_limits(16'd4, 16'd3, 16'd5, 1'b0);
        send_fields(9'd0, 1'b0, 1'b0);
        repeat (14) send_fields(9'd100, 1'b1, 1'b1);
        run_random(60, 1'b1, 1'b0);
        wait_drained();

        $display("Covered %0d ticks and %0d checked results under %0d limit sets,",
                 tracker.n_ticks, tracker.n_checked, n_settings);
        $display("ticks per mode off/held/h-alarm/released/r-alarm/emergency: %0d/%0d/%0d/%0d/%0d/%0d",
                 tracker.mode_ticks[dmv_pkg::MODE_OFF],
                 tracker.mode_ticks[dmv_pkg::MODE_HELD],
                 tracker.mode_ticks[dmv_pkg::MODE_HELD_ALARM],
                 tracker.mode_ticks[dmv_pkg::MODE_RELEASED],
                 tracker.mode_ticks[dmv_pkg::MODE_RELEASED_ALARM],
                 tracker.mode_ticks[dmv_pkg::MODE_EMERGENCY]);
        if (tracker.n_errors == 0 && tracker.pending() == 0)
            $display("dead_man_vigilance_controller regression: pass");
        else
            $display("dead_man_vigilance_controller regression: fail");
        $finish;
    end

endmodule
